### hdl/first_fit_page_region_allocator_assert.svh
// Assertion macros for the page region allocator.
`ifndef FIRST_FIT_PAGE_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_REGION_ALLOCATOR_ASSERT_SVH

// Condition a must be followed by condition b in the next cycle.
`define FFPRA_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("allocator check failed");

// Condition c must hold whenever out of reset.
`define FFPRA_ALWAYS(label, c) \
   label: assert property (@(posedge clock) disable iff (reset) (c)) \
      else $error("allocator check failed");

`endif

### hdl/ffpra_pkg.sv
package ffpra_pkg;

   localparam int MaxSegments = 32;
   localparam int IdxW        = $clog2(MaxSegments);
   localparam int CntW        = $clog2(MaxSegments + 1);
   localparam int PageShift   = 12;

   localparam logic [2:0] StOk    = 3'd0;
   localparam logic [2:0] StNoFit = 3'd1;
   localparam logic [2:0] StNoTag = 3'd2;
   localparam logic [2:0] StFull  = 3'd3;
   localparam logic [2:0] StZero  = 3'd4;

   localparam logic FuncAlloc = 1'b0;
   localparam logic FuncFree  = 1'b1;

   localparam logic CsrBase  = 1'b0;
   localparam logic CsrPages = 1'b1;

   typedef struct packed {
      logic        func;
      logic [15:0] owner_tag;
      logic [47:0] phys_address;
      logic [31:0] byte_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [35:0] virt_page_base;
      logic [20:0] page_count;
      logic [35:0] phys_page_base;
   } rsp_type;

   typedef struct packed {
      logic [35:0] start;
      logic [20:0] count;
      logic        free;
      logic [15:0] owner;
   } seg_type;

endpackage

### hdl/first_fit_page_region_allocator.sv
// First-fit page region allocator.
// Keeps an address-ordered table of up to 32 segments covering a window of
// virtual pages. Each segment is free or owned by a 16-bit tag.
// Request channel: req_data is taken at a clock edge where start is high and
// busy is low. func selects allocate (first fit, split remainder) or free
// (release lowest segment of the tag, merge with free neighbors).
// Response channel: one response per request, shown on rsp_data for exactly
// one cycle with rsp_valid high. The receiver cannot stall; it must take it.
// Sequencing: the table is scanned entry by entry; when a split or merge shifts
// the table, entries are moved one at a time; merge steps come one by one, and
// then the response is posted. busy is high throughout; the next request can be
// taken at the edge that ends the response cycle. One sequencer walks the table.
// CSR port: csr_we, csr_index, csr_wdata; writing either window register
// reinitializes the table to one free segment. Write only while idle.
// Reset: window base 0, 1024 pages, one free segment; no request pending.
module first_fit_page_region_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ffpra_pkg::req_type    req_data,
   output logic                  rsp_valid,
   output ffpra_pkg::rsp_type    rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [35:0]           csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_MERGE, S_DONE
   } state_type;

   state_type state_ff;
   logic [35:0] base_ff;
   logic [20:0] pages_ff;
   ffpra_pkg::seg_type seg_ff [ffpra_pkg::MaxSegments];
   logic [ffpra_pkg::CntW-1:0] used_ff;
   logic [ffpra_pkg::IdxW-1:0] idx_ff;   // scan index / found entry
   logic [ffpra_pkg::IdxW-1:0] mv_ff;    // shift cursor
   logic                       fwd_ff;   // forward merge still pending
   ffpra_pkg::req_type req_ff;
   logic [20:0] need_ff;
   logic [35:0] first_ff;
   logic        busy_ff, rsp_valid_ff;
   ffpra_pkg::rsp_type rsp_ff;
   // remainder of the split segment, captured during the scan and used when the slot opens
   logic [20:0] rem_ff;

   // page span of the buffer, combinational from req_data and latched at accept
   logic [48:0] last_byte;
   logic [36:0] span;
   assign last_byte = {1'b0, req_data.phys_address} + 49'(req_data.byte_length) - 49'd1;
   assign span = 37'(last_byte[48:ffpra_pkg::PageShift])
               - 37'(req_data.phys_address[47:ffpra_pkg::PageShift]) + 37'd1;

   ffpra_pkg::seg_type cur;
   logic [ffpra_pkg::CntW-1:0] idx_ext;
   logic at_last;   // scan sits on the last entry in use
   assign cur     = seg_ff[idx_ff];
   assign idx_ext = ffpra_pkg::CntW'(idx_ff);
   assign at_last = (idx_ext + 1'b1 >= used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         pages_ff     <= 21'd1024;
         used_ff      <= ffpra_pkg::CntW'(1);
         seg_ff[0] <= '{start: '0, count: 21'd1024, free: 1'b1, owner: '0};
      end else if (csr_we) begin
         rsp_valid_ff <= 1'b0;
         if (csr_index == ffpra_pkg::CsrBase) begin
            base_ff <= csr_wdata;
            seg_ff[0] <= '{start: csr_wdata, count: pages_ff, free: 1'b1, owner: '0};
         end else begin
            pages_ff <= csr_wdata[20:0];
            seg_ff[0] <= '{start: base_ff, count: csr_wdata[20:0], free: 1'b1,
                           owner: '0};
         end
         used_ff <= ffpra_pkg::CntW'(1);
      end else begin
         rsp_valid_ff <= (state_ff == S_DONE);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  need_ff  <= span[20:0];
                  first_ff <= req_data.phys_address[47:ffpra_pkg::PageShift];
                  idx_ff   <= '0;
                  busy_ff  <= 1'b1;
                  if (req_data.func == ffpra_pkg::FuncAlloc &&
                      req_data.byte_length == 32'd0) begin
                     rsp_ff <= '{status: ffpra_pkg::StZero, virt_page_base: '0,
                                 page_count: '0, phys_page_base: '0};
                     state_ff <= S_DONE;
                  end else begin
                     rsp_ff   <= '0;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (req_ff.func == ffpra_pkg::FuncAlloc) begin
                  if (cur.free && cur.count >= need_ff) begin
                     if (cur.count > need_ff &&
                         used_ff >= ffpra_pkg::CntW'(ffpra_pkg::MaxSegments)) begin
                        rsp_ff.status <= ffpra_pkg::StFull;
                        state_ff <= S_DONE;
                     end else begin
                        rsp_ff <= '{status: ffpra_pkg::StOk, virt_page_base: cur.start,
                                    page_count: need_ff, phys_page_base: first_ff};
                        seg_ff[idx_ff].free  <= 1'b0;
                        seg_ff[idx_ff].owner <= req_ff.owner_tag;
                        if (cur.count > need_ff) begin
                           seg_ff[idx_ff].count <= need_ff;
                           mv_ff    <= ffpra_pkg::IdxW'(used_ff);
                           state_ff <= S_SHUP;
                        end else begin
                           state_ff <= S_DONE;
                        end
                     end
                  end else if (at_last) begin
                     rsp_ff.status <= ffpra_pkg::StNoFit;
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  if (!cur.free && cur.owner == req_ff.owner_tag) begin
                     seg_ff[idx_ff].free  <= 1'b1;
                     seg_ff[idx_ff].owner <= '0;
                     rsp_ff.status <= ffpra_pkg::StOk;
                     state_ff <= S_MERGE;
                  end else if (at_last) begin
                     rsp_ff.status <= ffpra_pkg::StNoTag;
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_SHUP: begin
               // open a slot after idx_ff, one entry per cycle
               if (mv_ff == idx_ff + 1'b1) begin
                  seg_ff[mv_ff] <= '{start: seg_ff[idx_ff].start + 36'(need_ff),
                                     count: rem_ff, free: 1'b1, owner: '0};
                  used_ff  <= used_ff + 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  seg_ff[mv_ff] <= seg_ff[mv_ff - 1'b1];
                  mv_ff <= mv_ff - 1'b1;
               end
            end
            S_MERGE: begin
               // backward merge first, then forward merge
               if (idx_ff != '0 && seg_ff[idx_ff - 1'b1].free) begin
                  seg_ff[idx_ff - 1'b1].count <= seg_ff[idx_ff - 1'b1].count + cur.count;
                  mv_ff    <= idx_ff;
                  idx_ff   <= idx_ff - 1'b1;
                  fwd_ff   <= 1'b1;
                  state_ff <= S_SHDN;
               end else begin
                  rsp_ff.virt_page_base <= cur.start;
                  rsp_ff.page_count     <= cur.count;
                  if (idx_ext + 1'b1 < used_ff && seg_ff[idx_ff + 1'b1].free) begin
                     seg_ff[idx_ff].count <= cur.count + seg_ff[idx_ff + 1'b1].count;
                     mv_ff    <= idx_ff + 1'b1;
                     fwd_ff   <= 1'b0;
                     state_ff <= S_SHDN;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SHDN: begin
               if (ffpra_pkg::CntW'(mv_ff) + 1'b1 >= used_ff) begin
                  used_ff <= used_ff - 1'b1;
                  if (fwd_ff) begin
                     fwd_ff   <= 1'b0;
                     state_ff <= S_MERGE;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  seg_ff[mv_ff] <= seg_ff[mv_ff + 1'b1];
                  mv_ff <= mv_ff + 1'b1;
               end
            end
            S_DONE: begin
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         rem_ff <= cur.count - need_ff;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `include "first_fit_page_region_allocator_assert.svh"

   `FFPRA_ALWAYS(a_rsp_when_idle, !rsp_valid || !busy)
   `FFPRA_ALWAYS(a_used_range, used_ff != '0 &&
      used_ff <= ffpra_pkg::CntW'(ffpra_pkg::MaxSegments))
   `FFPRA_NEXT(a_accept_busy, start && !busy && !csr_we, busy)

endmodule
